/* hw/rtl/mrcs_pkg.sv */
// Shared constants, types and helpers for the matrix row and column sum unit.
package mrcs_pkg;

  // Table bounds
  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned MAX_COLS = 32;

  // Widths
  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned ROWS_W   = 7;                      // row_count register
  localparam int unsigned COLS_W   = 6;                      // col_count register
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);       // row position
  localparam int unsigned COL_W    = $clog2(MAX_COLS);       // column position
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned TDATA_OUT_W = 56;

  // Queue between the front and the back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ROW   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GRAND = 2'd2;

  // Effective table dimensions after clamping
  typedef struct packed {
    logic [ROWS_W-1:0] rows;
    logic [COLS_W-1:0] cols;
  } dims_t;

  // One classified element on its way to the back
  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
    logic                     row_end;
    logic                     table_end;
  } elem_t;

  // Zero counts as one, above the bound saturates
  function automatic logic [ROWS_W-1:0] clamp_rows(input logic [ROWS_W-1:0] v);
    if (v == '0) return ROWS_W'(1);
    if (v > ROWS_W'(MAX_ROWS)) return ROWS_W'(MAX_ROWS);
    return v;
  endfunction

  function automatic logic [COLS_W-1:0] clamp_cols(input logic [COLS_W-1:0] v);
    if (v == '0) return COLS_W'(1);
    if (v > COLS_W'(MAX_COLS)) return COLS_W'(MAX_COLS);
    return v;
  endfunction

endpackage

/* hw/rtl/mrcs_front.sv */
// Front end: takes elements and tags them with their table position.
module mrcs_front
  import mrcs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_clear,
  input  dims_t                    dims,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic signed [ELEM_W-1:0] s_tdata,   // element_value
  input  logic                     q_full,
  output logic                     q_push,
  output elem_t                    q_wdata
);

  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic             row_end;
  logic             table_end;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  // Position classification
  assign row_end   = ({1'b0, col_pos} + COLS_W'(1)) >= dims.cols;
  assign table_end = row_end && (({1'b0, row_pos} + ROWS_W'(1)) >= dims.rows);

  always_comb begin
    q_wdata.value     = s_tdata;
    q_wdata.col       = col_pos;
    q_wdata.row       = row_pos;
    q_wdata.row_end   = row_end;
    q_wdata.table_end = table_end;
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (q_push) begin
      if (!row_end) begin
        col_pos <= col_pos + COL_W'(1);
      end else begin
        col_pos <= '0;
        row_pos <= table_end ? '0 : row_pos + ROW_W'(1);
      end
    end
  end

endmodule

/* hw/rtl/mrcs_queue.sv */
// Short queue of classified elements between front and back.
module mrcs_queue
  import mrcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  elem_t wdata,
  input  logic  pop,
  output elem_t rdata,
  output logic  full,
  output logic  empty
);

  elem_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = fill == (QPTR_W+1)'(QDEPTH);
  assign empty = fill == '0;
  assign rdata = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

/* hw/rtl/mrcs_back.sv */
// Back end: accumulates row, column and grand sums and emits results.
module mrcs_back
  import mrcs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_clear,
  input  dims_t                     dims,
  input  elem_t                     q_rdata,
  input  logic                      q_empty,
  output logic                      q_pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [TDATA_OUT_W-1:0]    m_tdata,  // sum_value[47:0], sum_index[53:48], zero pad
  output logic [KIND_W-1:0]         m_tuser,  // sum_kind
  output logic                      m_tlast   // last
);

  localparam logic [1:0] ST_ACC   = 2'd0;
  localparam logic [1:0] ST_COLS  = 2'd1;
  localparam logic [1:0] ST_GRAND = 2'd2;

  logic [1:0]       state;
  logic [COL_W-1:0] drain_idx;

  logic [SUM_W-1:0] row_acc;
  logic [SUM_W-1:0] grand_acc;
  logic [SUM_W-1:0] col_acc [MAX_COLS];
  logic [MAX_COLS-1:0] col_vld;

  logic [SUM_W-1:0]   val_ext;
  logic [SUM_W-1:0]   row_sum;
  logic [COL_W-1:0]   col_rd_idx;
  logic [SUM_W-1:0]   col_rd;
  logic               load_ok;
  logic               out_load;

  logic [SUM_W-1:0]   sum_value;
  logic [INDEX_W-1:0] sum_index;

  assign load_ok = !m_tvalid || m_tready;
  assign val_ext = {{(SUM_W-ELEM_W){q_rdata.value[ELEM_W-1]}}, q_rdata.value};
  assign row_sum = row_acc + val_ext;

  // Column sum read: accumulate address or drain address
  assign col_rd_idx = (state == ST_ACC) ? q_rdata.col : drain_idx;
  assign col_rd     = col_vld[col_rd_idx] ? col_acc[col_rd_idx] : '0;

  assign q_pop = (state == ST_ACC) && !q_empty && (!q_rdata.row_end || load_ok);

  // Output register takes a new result this cycle
  assign out_load = (q_pop && q_rdata.row_end) ||
                    ((state inside {ST_COLS, ST_GRAND}) && load_ok);

  assign m_tdata = {{(TDATA_OUT_W-SUM_W-INDEX_W){1'b0}}, sum_index, sum_value};

  // Column sums, no reset: an entry without its valid bit reads as zero
  always_ff @(posedge clk) begin
    if (q_pop) begin
      col_acc[q_rdata.col] <= col_rd + val_ext;
    end
  end

  // Control, running sums and output register
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      state     <= ST_ACC;
      drain_idx <= '0;
      row_acc   <= '0;
      grand_acc <= '0;
      col_vld   <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_ACC: begin
          if (q_pop) begin
            col_vld[q_rdata.col] <= 1'b1;
            grand_acc <= grand_acc + val_ext;
            if (q_rdata.row_end) begin
              row_acc   <= '0;
              sum_value <= row_sum;
              m_tuser   <= KIND_ROW;
              sum_index <= INDEX_W'(q_rdata.row);
              m_tlast   <= !q_rdata.table_end;
              if (q_rdata.table_end) begin
                state     <= ST_COLS;
                drain_idx <= '0;
              end
            end else begin
              row_acc <= row_sum;
            end
          end
        end
        ST_COLS: begin
          if (load_ok) begin
            sum_value <= col_rd;
            m_tuser   <= KIND_COL;
            sum_index <= INDEX_W'(drain_idx);
            m_tlast   <= 1'b0;
            if ({1'b0, drain_idx} == dims.cols - COLS_W'(1)) begin
              state <= ST_GRAND;
            end else begin
              drain_idx <= drain_idx + COL_W'(1);
            end
          end
        end
        ST_GRAND: begin
          if (load_ok) begin
            sum_value <= grand_acc;
            m_tuser   <= KIND_GRAND;
            sum_index <= '0;
            m_tlast   <= 1'b1;
            grand_acc <= '0;
            col_vld   <= '0;
            state     <= ST_ACC;
          end
        end
        default: begin
          state <= ST_ACC;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // No element leaves the queue while the column sums drain
  a_no_pop_in_drain: assert property (@(posedge clk) disable iff (rst)
    (state != ST_ACC) |-> !q_pop)
    else $error("element taken during drain");

  // Drain index stays inside the table width
  a_drain_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COLS) |-> ({1'b0, drain_idx} < dims.cols))
    else $error("drain index beyond column count");

  // The table's last element starts the drain
  a_table_end_drains: assert property (@(posedge clk) disable iff (rst || cfg_clear)
    (q_pop && q_rdata.table_end) |=> (state == ST_COLS))
    else $error("table end did not start drain");

  // Emitting the grand total leaves all sums cleared
  a_grand_clears: assert property (@(posedge clk) disable iff (rst || cfg_clear)
    (state == ST_GRAND && load_ok) |=> (grand_acc == '0 && col_vld == '0 && m_tlast))
    else $error("sums not cleared after grand total");
`endif

endmodule

/* hw/rtl/matrix_row_column_sums_unit.sv */
// Path: an element passes through the queue, and a row-closing one then loads its row sum into the output register.
// Throughput: one element per cycle; a table end adds a drain of the col_count
// column sums and the grand total, and input stalls once the four-entry queue fills.
// Reset: synchronous, active high; dimensions return to 1 by 1 and all sums
// clear. A write to row_count or col_count also restarts the table.
module matrix_row_column_sums_unit
  import mrcs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [ELEM_W-1:0]         s_tdata,   // element_value
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [TDATA_OUT_W-1:0]    m_tdata,   // sum_value[47:0], sum_index[53:48], zero pad
  output logic [KIND_W-1:0]         m_tuser,   // sum_kind
  output logic                      m_tlast    // last
);

  logic [ROWS_W-1:0] row_count;
  logic [COLS_W-1:0] col_count;
  logic              cfg_clear;
  dims_t             dims;

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  elem_t q_wdata;
  elem_t q_rdata;

  // Configuration registers
  assign cfg_clear = cfg_wen && (cfg_index inside {REG_ROW_COUNT, REG_COL_COUNT});

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROWS_W'(1);
      col_count <= COLS_W'(1);
    end else if (cfg_wen) begin
      if (cfg_index == REG_ROW_COUNT) row_count <= cfg_wdata[ROWS_W-1:0];
      if (cfg_index == REG_COL_COUNT) col_count <= cfg_wdata[COLS_W-1:0];
    end
  end

  assign dims.rows = clamp_rows(row_count);
  assign dims.cols = clamp_cols(col_count);

  mrcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_clear (cfg_clear),
    .dims      (dims),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  mrcs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  mrcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_clear (cfg_clear),
    .dims      (dims),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

/* bench/tb_matrix_row_column_sums_unit.sv */
// Self-checking bench for the matrix row and column sum unit, with its own sum predictor.
module tb_matrix_row_column_sums_unit;
  import mrcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAD_W        = TDATA_OUT_W - SUM_W - INDEX_W;
  localparam int unsigned ITEMS_TOTAL  = 160;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_LIMIT   = 3000;

  // Indexes past the register list: writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [ELEM_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] ELEM_MIN = 32'h8000_0000;
  localparam logic [ELEM_W-1:0] ELEM_NEG1 = 32'hFFFF_FFFF;

  // One reported sum as it leaves the block
  typedef struct packed {
    logic [SUM_W-1:0]   value;
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] index;
    logic               last;
    logic [PAD_W-1:0]   pad;
  } sum_rec_t;

  // Running-sum predictor and store of sums still to come
  class sum_scoreboard;
    logic [ROWS_W-1:0] rows_reg;
    logic [COLS_W-1:0] cols_reg;
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic [SUM_W-1:0]  row_acc;
    logic [SUM_W-1:0]  grand_acc;
    logic [SUM_W-1:0]  col_acc [MAX_COLS];
    sum_rec_t          expected_sums [$];
    int                errors;

    function new();
      rows_reg = ROWS_W'(1);
      cols_reg = COLS_W'(1);
      errors   = 0;
      clear_table();
    endfunction

    function void clear_table();
      col_pos   = 0;
      row_pos   = 0;
      row_acc   = '0;
      grand_acc = '0;
      foreach (col_acc[j]) col_acc[j] = '0;
    endfunction

    // Zero means one, anything past the bound saturates
    function int unsigned dim(int unsigned v, int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
    endfunction

    function int unsigned rows_eff();
      return dim(rows_reg, MAX_ROWS);
    endfunction

    function int unsigned cols_eff();
      return dim(cols_reg, MAX_COLS);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_ROW_COUNT: begin
          rows_reg = d[ROWS_W-1:0];
          clear_table();
        end
        REG_COL_COUNT: begin
          cols_reg = d[COLS_W-1:0];
          clear_table();
        end
        default: ;
      endcase
    endfunction

    function void expect_sum(logic [SUM_W-1:0] v, logic [KIND_W-1:0] k, int unsigned idx,
                             logic lst);
      sum_rec_t r;
      r.value = v;
      r.kind  = k;
      r.index = INDEX_W'(idx);
      r.last  = lst;
      r.pad   = '0;
      expected_sums.push_back(r);
    endfunction

    // Fold one accepted element into the sums and queue what it releases
    function void add_element(logic [ELEM_W-1:0] e);
      logic [SUM_W-1:0] v;
      logic             table_end;
      v = {{(SUM_W-ELEM_W){e[ELEM_W-1]}}, e};
      row_acc          += v;
      col_acc[col_pos] += v;
      grand_acc        += v;
      if (col_pos + 1 < cols_eff()) begin
        col_pos++;
        return;
      end
      table_end = (row_pos + 1 >= rows_eff());
      expect_sum(row_acc, KIND_ROW, row_pos, !table_end);
      row_acc = '0;
      col_pos = 0;
      if (!table_end) begin
        row_pos++;
        return;
      end
      for (int unsigned j = 0; j < cols_eff(); j++)
        expect_sum(col_acc[j], KIND_COL, j, 1'b0);
      expect_sum(grand_acc, KIND_GRAND, 0, 1'b1);
      clear_table();
    endfunction

    function void check_sum(sum_rec_t got);
      sum_rec_t want;
      if (expected_sums.size() == 0) begin
        errors++;
        $display("%0t: unexpected sum value %h kind %0d index %0d last %0b", $time,
                 got.value, got.kind, got.index, got.last);
        return;
      end
      want = expected_sums.pop_front();
      if (got.value !== want.value || got.kind !== want.kind || got.index !== want.index ||
          got.last !== want.last || got.pad !== want.pad) begin
        errors++;
        $display("%0t: sum mismatch, expected value %h kind %0d index %0d last %0b pad %0h",
                 $time, want.value, want.kind, want.index, want.last, want.pad);
        $display("%0t:               got value %h kind %0d index %0d last %0b pad %0h",
                 $time, got.value, got.kind, got.index, got.last, got.pad);
      end
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [ELEM_W-1:0]      s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic [KIND_W-1:0]      m_tuser;
  logic                   m_tlast;

  sum_scoreboard sb = new();
  int unsigned   items_sent = 0;
  bit            calm = 1'b0;     // no idling on either side
  bit            hold_req = 1'b0; // receiver to hold off for a long stretch

  matrix_row_column_sums_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [ELEM_W-1:0] rand_element();
    case ($urandom_range(0, 9))
      0: return ELEM_MAX;
      1: return ELEM_MIN;
      2: return ELEM_NEG1;
      3: return $urandom_range(0, 1) ? 32'd0 : 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one element and wait for its transfer
  task automatic send_element(input logic [ELEM_W-1:0] e);
    int unsigned gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= e;
    do @(posedge clk); while (!s_tready);
    sb.add_element(e);
    items_sent++;
  endtask

  // Register write once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk) s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
    @(negedge clk) cfg_wen <= 1'b0;
  endtask

  task automatic set_dims(input logic [CFG_DATA_W-1:0] r, input logic [CFG_DATA_W-1:0] c);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_ROW_COUNT, r);
      write_reg(REG_COL_COUNT, c);
    end else begin
      write_reg(REG_COL_COUNT, c);
      write_reg(REG_ROW_COUNT, r);
    end
  endtask

  // Receiver: random stalls, plus the long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0 && !calm) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready   <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_mon
    sum_rec_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.value = m_tdata[SUM_W-1:0];
      got.kind  = m_tuser;
      got.index = m_tdata[SUM_W +: INDEX_W];
      got.last  = m_tlast;
      got.pad   = m_tdata[TDATA_OUT_W-1 -: PAD_W];
      sb.check_sum(got);
    end
  end

  // Watchdog: too long without any transfer on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned phase;
    int unsigned tables;
    int unsigned n;
    int unsigned size;
    logic [CFG_DATA_W-1:0] rw;
    logic [CFG_DATA_W-1:0] cw;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Default 1 by 1 table: every element closes a table
    send_element(ELEM_MAX);
    send_element(ELEM_MIN);
    send_element(ELEM_NEG1);
    send_element(32'd0);

    // Writes to unknown indexes must not restart a half-done row
    write_reg(REG_COL_COUNT, 7'd2);
    send_element(ELEM_MAX);
    write_reg(REG_SPARE_A, 7'h7F);
    write_reg(REG_SPARE_B, 7'h2A);
    send_element(ELEM_MAX);

    // Zero counts behave as one
    set_dims(7'd0, 7'd0);
    send_element(32'hAAAA_AAAA);

    // Extremes alternating in a 2 by 3 table
    set_dims(7'd2, 7'd3);
    send_element(ELEM_MAX);
    send_element(ELEM_MIN);
    send_element(ELEM_MAX);
    send_element(ELEM_MIN);
    send_element(ELEM_MAX);
    send_element(ELEM_MIN);

    // Register writes in mid-table restart it
    write_reg(REG_ROW_COUNT, 7'd3);
    repeat (4) send_element(rand_element());
    write_reg(REG_COL_COUNT, 7'd2);
    repeat (4) send_element(rand_element());

    // Random phases, each with its own table shape
    phase = 0;
    while (items_sent < ITEMS_TOTAL) begin
      calm   = ($urandom_range(0, 3) == 0);
      tables = $urandom_range(1, 3);
      case (phase)
        0: begin
          rw = 7'd127;
          cw = 7'd1;
          tables = 1;
        end
        1: begin
          rw = 7'd1;
          cw = 7'h7F;
          tables = 1;
        end
        2: begin
          rw = 7'd1;
          cw = 7'd2;
          tables = 12;
        end
        default: begin
          rw = CFG_DATA_W'($urandom_range(0, 4));
          cw = CFG_DATA_W'($urandom_range(0, 5));
          if ($urandom_range(0, 3) == 0) cw[CFG_DATA_W-1] = 1'b1;
        end
      endcase
      set_dims(rw, cw);
      if ($urandom_range(0, 4) == 0)
        write_reg(REG_SPARE_B, CFG_DATA_W'($urandom_range(0, 127)));
      size = sb.rows_eff() * sb.cols_eff();
      n = tables * size;
      if (size > 1 && $urandom_range(0, 3) == 0) n += $urandom_range(1, size - 1);
      if (phase == 2) begin
        // Back-pressure: receiver holds off while elements keep coming
        calm = 1'b1;
        hold_req = 1'b1;
      end
      repeat (n) send_element(rand_element());
      phase++;
    end

    // Drain
    @(negedge clk) s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
